// ----- src/assert_macros.svh -----
// Assertion helpers for the range max and sum block.
// Both sample on clk and are switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define QT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/qtr_pkg.sv -----
// ----------------------------------------------------------------------------
// qtr_pkg
// Shared types and constants of the quadtree range maximum and sum block.
// ----------------------------------------------------------------------------
package qtr_pkg;

	localparam int GRID_SIDE_DEF  = 64;
	localparam int TREE_NODES_DEF = 8192;

	localparam int CNT_W  = 7;
	localparam int COORD_IN_W = 7;
	localparam int VAL_W  = 32;
	localparam int SUM_W  = 44;
	localparam int OP_W   = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

	localparam logic signed [VAL_W-1:0] EMPTY_MAX = -32'sd1000000011;

	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Running maximum and sum, with a flag for whether anything was seen.
	typedef struct packed {
		logic                    have;
		logic signed [VAL_W-1:0] max_v;
		logic signed [SUM_W-1:0] sum_v;
	} acc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VISIT,
		ST_CHILD,
		ST_LEAF,
		ST_COVER,
		ST_DONE
	} state_t;

endpackage

// ----- src/qtr_ram.sv -----
// ----------------------------------------------------------------------------
// qtr_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module qtr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/qtr_alu.sv -----
// ----------------------------------------------------------------------------
// qtr_alu
// Shared combine unit: folds one maximum and sum into a running accumulator.
// ----------------------------------------------------------------------------
module qtr_alu import qtr_pkg::*; (
	input  acc_t                    acc_in,
	input  logic signed [VAL_W-1:0] val_max,
	input  logic signed [SUM_W-1:0] val_sum,
	output acc_t                    acc_out
);

	always_comb begin
		acc_out.have  = 1'b1;
		if (!acc_in.have || ($signed(val_max) > $signed(acc_in.max_v))) begin
			acc_out.max_v = val_max;
		end else begin
			acc_out.max_v = acc_in.max_v;
		end
		acc_out.sum_v = acc_in.sum_v + val_sum;
	end

endmodule

// ----- src/quadtree_range_max_sum.sv -----
// ----------------------------------------------------------------------------
// quadtree_range_max_sum
// Grid of signed cells with a quadtree that answers rectangle max and sum.
// ----------------------------------------------------------------------------
// A write word stores one cell and gives no result. A build word walks the
// whole quadtree depth first with a small frame stack. A node that covers a
// single cell is entered and then folds the cell it read. Any other node is
// entered, then steps through its child slots one at a time, then returns.
// A query word steps through every child slot of each node that straddles
// the rectangle edge; a fully covered node is entered and folded into the
// answer, and a node outside the rectangle is entered and left at once. How
// many nodes a query visits depends on how long the part of the rectangle
// edge inside the grid is. In every case the pace is set by the one shared
// combine unit and by the single read port of each node memory, as one node
// is handled at a time. The block takes no new word while a build or query
// is running, but it does take one while a finished result still waits in
// the output register. The cell and node memories have no reset; a build
// that reads a cell never written gives undefined node contents. Queries
// made before the first build report an empty rectangle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadtree_range_max_sum import qtr_pkg::*; #(
	parameter int GRID_SIDE  = GRID_SIDE_DEF,
	parameter int TREE_NODES = TREE_NODES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration write channel.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CNT_W-1:0]             cfg_data,
	// Input words.
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [OP_W-1:0]              op,
	input  logic [COORD_IN_W-1:0]        cell_row,
	input  logic [COORD_IN_W-1:0]        cell_col,
	input  logic signed [VAL_W-1:0]      cell_value,
	input  logic [COORD_IN_W-1:0]        row_low,
	input  logic [COORD_IN_W-1:0]        col_low,
	input  logic [COORD_IN_W-1:0]        row_high,
	input  logic [COORD_IN_W-1:0]        col_high,
	// Result words.
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         result_kind,
	output logic signed [VAL_W-1:0]      max_value,
	output logic signed [SUM_W-1:0]      sum_value,
	output logic                         is_empty
);

	localparam int LOG   = $clog2(GRID_SIDE);
	localparam int KW    = 2 * LOG + 3;
	localparam int KCW   = (KW > 24) ? KW : 24;
	localparam int NAW   = $clog2(TREE_NODES);
	localparam int SD    = LOG + 2;
	localparam int SPW   = $clog2(SD);
	localparam int SPCW  = $clog2(SD + 1);
	localparam int CWG   = $clog2(GRID_SIDE + 1);
	localparam int CW    = (CWG > COORD_IN_W) ? CWG : COORD_IN_W;
	localparam int GAW   = (GRID_SIDE > 1) ? $clog2(GRID_SIDE * GRID_SIDE) : 1;

	// One node of the walk: its index, its rectangle, the next child slot and,
	// during a build, the maximum and sum gathered from its children so far.
	typedef struct packed {
		logic [KW-1:0] k;
		logic [CW-1:0] r1;
		logic [CW-1:0] c1;
		logic [CW-1:0] r2;
		logic [CW-1:0] c2;
		logic [2:0]    ci;
		acc_t          acc;
	} frame_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0] row_count_q, col_count_q;
	logic [CW-1:0]    built_rows_q, built_cols_q;
	logic [CW-1:0]    qx1_q, qy1_q, qx2_q, qy2_q;
	logic             query_mode_q;
	acc_t             qacc_q;
	frame_t           cur_q;
	frame_t           stk_q [SD];
	logic [SPCW-1:0]  sp_q;

	logic                    res_valid_q;
	logic                    result_kind_q;
	logic signed [VAL_W-1:0] max_value_q;
	logic signed [SUM_W-1:0] sum_value_q;
	logic                    is_empty_q;

	// ------------------------------------------------------------------
	// Decode of the current node.
	// ------------------------------------------------------------------
	logic          accept;
	logic          node_empty, is_leaf, disjoint, covered, k_in;
	logic          at_root, all_done, child_empty, res_free;
	logic [CW:0]   rsum, csum;
	logic [CW-1:0] rm, cm, ch_r1, ch_c1, ch_r2, ch_c2;
	logic [KW-1:0] kid;
	logic [CW-1:0] build_rows, build_cols, ext_rows, ext_cols;
	frame_t        parent;
	logic [SPCW-1:0] sp_m1;

	assign accept   = item_valid && !item_stall;
	assign res_free = !res_valid_q || !res_stall;

	assign node_empty = (cur_q.r1 > cur_q.r2) || (cur_q.c1 > cur_q.c2);
	assign is_leaf    = (cur_q.r1 == cur_q.r2) && (cur_q.c1 == cur_q.c2);
	assign disjoint   = (qx1_q > cur_q.r2) || (qy1_q > cur_q.c2) ||
	                    (qx2_q < cur_q.r1) || (qy2_q < cur_q.c1);
	assign covered    = (qx1_q <= cur_q.r1) && (qy1_q <= cur_q.c1) &&
	                    (cur_q.r2 <= qx2_q) && (cur_q.c2 <= qy2_q);
	assign k_in       = KCW'(cur_q.k) < KCW'(TREE_NODES);
	assign at_root    = (sp_q == '0);
	assign all_done   = cur_q.ci[2];

	assign rsum = {1'b0, cur_q.r1} + {1'b0, cur_q.r2};
	assign csum = {1'b0, cur_q.c1} + {1'b0, cur_q.c2};
	assign rm   = rsum[CW:1];
	assign cm   = csum[CW:1];

	always_comb begin
		ch_r1 = cur_q.ci[0] ? CW'(rm + CW'(1)) : cur_q.r1;
		ch_r2 = cur_q.ci[0] ? cur_q.r2 : rm;
		ch_c1 = cur_q.ci[1] ? CW'(cm + CW'(1)) : cur_q.c1;
		ch_c2 = cur_q.ci[1] ? cur_q.c2 : cm;
	end

	assign kid         = KW'({cur_q.k, 2'b00}) - KW'(2) + KW'(cur_q.ci[1:0]);
	assign child_empty = (ch_r1 > ch_r2) || (ch_c1 > ch_c2);

	assign sp_m1  = sp_q - SPCW'(1);
	assign parent = stk_q[sp_m1[SPW-1:0]];

	assign ext_rows   = CW'(row_count_q);
	assign ext_cols   = CW'(col_count_q);
	assign build_rows = (ext_rows > CW'(GRID_SIDE)) ? CW'(GRID_SIDE) : ext_rows;
	assign build_cols = (ext_cols > CW'(GRID_SIDE)) ? CW'(GRID_SIDE) : ext_cols;

	// ------------------------------------------------------------------
	// Memories: cell grid and the two node stores.
	// ------------------------------------------------------------------
	logic                    grid_we;
	logic [GAW-1:0]          grid_wa, grid_ra;
	logic signed [VAL_W-1:0] grid_rd;
	logic                    node_we;
	logic [NAW-1:0]          node_wa, node_ra;
	logic signed [VAL_W-1:0] node_max_wd, node_max_rd;
	logic signed [SUM_W-1:0] node_sum_wd, node_sum_rd;

	assign grid_we = accept && (op == OP_WRITE) &&
	                 (CW'(cell_row) >= CW'(1)) && (CW'(cell_row) <= CW'(GRID_SIDE)) &&
	                 (CW'(cell_col) >= CW'(1)) && (CW'(cell_col) <= CW'(GRID_SIDE));
	assign grid_wa = GAW'((CW'(cell_row) - CW'(1)) * GRID_SIDE + (CW'(cell_col) - CW'(1)));
	assign grid_ra = GAW'((cur_q.r1 - CW'(1)) * GRID_SIDE + (cur_q.c1 - CW'(1)));

	qtr_ram #(.WIDTH(VAL_W), .DEPTH(GRID_SIDE * GRID_SIDE)) u_grid (
		.clk     (clk),
		.wr_en   (grid_we),
		.wr_addr (grid_wa),
		.wr_data (cell_value),
		.rd_addr (grid_ra),
		.rd_data (grid_rd)
	);

	qtr_ram #(.WIDTH(VAL_W), .DEPTH(TREE_NODES)) u_node_max (
		.clk     (clk),
		.wr_en   (node_we),
		.wr_addr (node_wa),
		.wr_data (node_max_wd),
		.rd_addr (node_ra),
		.rd_data (node_max_rd)
	);

	qtr_ram #(.WIDTH(SUM_W), .DEPTH(TREE_NODES)) u_node_sum (
		.clk     (clk),
		.wr_en   (node_we),
		.wr_addr (node_wa),
		.wr_data (node_sum_wd),
		.rd_addr (node_ra),
		.rd_data (node_sum_rd)
	);

	// ------------------------------------------------------------------
	// Shared combine unit. During a build it folds a finished child into
	// its parent; during a query it folds a covered node into the answer.
	// ------------------------------------------------------------------
	acc_t                    alu_in, alu_out;
	logic signed [VAL_W-1:0] alu_max;
	logic signed [SUM_W-1:0] alu_sum;
	logic signed [VAL_W-1:0] ret_max;
	logic signed [SUM_W-1:0] ret_sum;

	qtr_alu u_alu (
		.acc_in  (alu_in),
		.val_max (alu_max),
		.val_sum (alu_sum),
		.acc_out (alu_out)
	);

	// ------------------------------------------------------------------
	// Next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && ((op == OP_BUILD) || (op == OP_QUERY))) begin
					state_d = ST_VISIT;
				end
			end
			ST_VISIT: begin
				if (!query_mode_q) begin
					priority if (node_empty) state_d = ST_DONE;
					else if (is_leaf)        state_d = ST_LEAF;
					else                     state_d = ST_CHILD;
				end else begin
					priority if (node_empty || disjoint) begin
						state_d = at_root ? ST_DONE : ST_CHILD;
					end else if (covered) begin
						state_d = ST_COVER;
					end else begin
						state_d = ST_CHILD;
					end
				end
			end
			ST_CHILD: begin
				priority if (all_done) begin
					state_d = at_root ? ST_DONE : ST_CHILD;
				end else if (!query_mode_q && child_empty) begin
					state_d = ST_CHILD;
				end else begin
					state_d = ST_VISIT;
				end
			end
			ST_LEAF, ST_COVER: begin
				state_d = at_root ? ST_DONE : ST_CHILD;
			end
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Control outputs of the sequencer.
	// ------------------------------------------------------------------
	always_comb begin
		item_stall  = (state_q != ST_IDLE);
		node_ra     = NAW'(cur_q.k);
		node_wa     = NAW'(cur_q.k);
		node_we     = 1'b0;
		ret_max     = cur_q.acc.max_v;
		ret_sum     = cur_q.acc.sum_v;
		if (state_q == ST_LEAF) begin
			ret_max = grid_rd;
			ret_sum = SUM_W'(grid_rd);
		end
		node_max_wd = ret_max;
		node_sum_wd = ret_sum;
		if (!query_mode_q && k_in &&
		    ((state_q == ST_LEAF) || ((state_q == ST_CHILD) && all_done))) begin
			node_we = 1'b1;
		end
		// A node beyond the store reads back as zero.
		if (!k_in) begin
			ret_max = '0;
			ret_sum = '0;
		end
		if (state_q == ST_COVER) begin
			alu_in  = qacc_q;
			alu_max = k_in ? node_max_rd : '0;
			alu_sum = k_in ? node_sum_rd : '0;
		end else begin
			alu_in  = parent.acc;
			alu_max = ret_max;
			alu_sum = ret_sum;
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------
	logic   do_pop;
	frame_t popped;

	always_comb begin
		do_pop = 1'b0;
		unique case (state_q)
			ST_VISIT: do_pop = query_mode_q && (node_empty || disjoint) && !at_root;
			ST_CHILD: do_pop = all_done && !at_root;
			ST_LEAF, ST_COVER: do_pop = !at_root;
			default: do_pop = 1'b0;
		endcase
	end

	// The parent frame as it stands after a return: on its next child slot
	// and, during a build, with the finished child folded in.
	always_comb begin
		popped    = parent;
		popped.ci = parent.ci + 3'd1;
		if (!query_mode_q) begin
			popped.acc = alu_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			row_count_q  <= COUNT_RESET;
			col_count_q  <= COUNT_RESET;
			built_rows_q <= '0;
			built_cols_q <= '0;
			sp_q         <= '0;
			query_mode_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ROW_COUNT: row_count_q <= cfg_data;
					REG_COL_COUNT: col_count_q <= cfg_data;
					default: ;
				endcase
			end

			if ((state_q == ST_DONE) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && ((op == OP_BUILD) || (op == OP_QUERY))) begin
						query_mode_q <= (op == OP_QUERY);
						sp_q         <= '0;
						qacc_q       <= '0;
						qx1_q        <= CW'(row_low);
						qy1_q        <= CW'(col_low);
						qx2_q        <= CW'(row_high);
						qy2_q        <= CW'(col_high);
						cur_q.k      <= KW'(1);
						cur_q.r1     <= CW'(1);
						cur_q.c1     <= CW'(1);
						cur_q.ci     <= '0;
						cur_q.acc    <= '0;
						if (op == OP_BUILD) begin
							built_rows_q <= build_rows;
							built_cols_q <= build_cols;
							cur_q.r2     <= build_rows;
							cur_q.c2     <= build_cols;
						end else begin
							cur_q.r2     <= built_rows_q;
							cur_q.c2     <= built_cols_q;
						end
					end
				end
				ST_CHILD: begin
					if (!all_done) begin
						if (!query_mode_q && child_empty) begin
							cur_q.ci <= cur_q.ci + 3'd1;
						end else begin
							stk_q[sp_q[SPW-1:0]] <= cur_q;
							sp_q      <= sp_q + SPCW'(1);
							cur_q.k   <= kid;
							cur_q.r1  <= ch_r1;
							cur_q.c1  <= ch_c1;
							cur_q.r2  <= ch_r2;
							cur_q.c2  <= ch_c2;
							cur_q.ci  <= '0;
							cur_q.acc <= '0;
						end
					end
				end
				ST_COVER: begin
					qacc_q <= alu_out;
				end
				ST_DONE: begin
					if (res_free) begin
						if (!query_mode_q) begin
							result_kind_q <= KIND_BUILD;
							max_value_q   <= '0;
							sum_value_q   <= '0;
							is_empty_q    <= 1'b0;
						end else begin
							result_kind_q <= KIND_QUERY;
							max_value_q   <= qacc_q.have ? qacc_q.max_v : EMPTY_MAX;
							sum_value_q   <= qacc_q.have ? qacc_q.sum_v : '0;
							is_empty_q    <= !qacc_q.have;
						end
					end
				end
				default: ;
			endcase

			// Return to the parent frame and move on to its next child slot.
			if (do_pop) begin
				sp_q  <= sp_m1;
				cur_q <= popped;
			end
		end
	end

	assign cfg_ready   = 1'b1;
	assign res_valid   = res_valid_q;
	assign result_kind = result_kind_q;
	assign max_value   = max_value_q;
	assign sum_value   = sum_value_q;
	assign is_empty    = is_empty_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`QT_ASSERT_NOW(a_stack_bound, 1'b1, sp_q <= SPCW'(SD - 1), "frame stack overrun")
	`QT_ASSERT_NEXT(a_done_emits, (state_q == ST_DONE) && res_free, res_valid && (state_q == ST_IDLE), "finished walk gave no result")
	`QT_ASSERT_NOW(a_build_zero, res_valid && (result_kind == KIND_BUILD), (sum_value == '0) && !is_empty && (max_value == '0), "build result not cleared")
	`QT_ASSERT_NOW(a_empty_max, res_valid && is_empty, (max_value == EMPTY_MAX) && (sum_value == '0), "empty answer malformed")

endmodule
